// ===== rtl/bhv_pkg.sv =====
// Package for the bitstream header validator: beat types, verdict codes,
// scan constants, register indexes and the firmware magic table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bhv_pkg;

	// Scan limits
	localparam int SCAN_WINDOW      = 4096;
	localparam int MIN_HEADER_BYTES = 64;
	localparam int COUNT_W          = 13;
	localparam int MAGIC_LEN        = 4;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MIN_LENGTH     = 2'd0,
		REG_MAX_LENGTH     = 2'd1,
		REG_SYNC_PATTERN   = 2'd2,
		REG_DEVICE_PATTERN = 2'd3
	} cfg_reg_t;

	localparam logic [31:0] MIN_LENGTH_RST     = 32'd524288;
	localparam logic [31:0] MAX_LENGTH_RST     = 32'd8388608;
	localparam logic [15:0] SYNC_PATTERN_RST   = 16'hA5C3;
	localparam logic [31:0] DEVICE_PATTERN_RST = 32'h0001_481B;

	typedef enum logic [2:0] {
		VERDICT_ACCEPTED     = 3'd0,
		VERDICT_TOO_SHORT    = 3'd1,
		VERDICT_FW_MAGIC     = 3'd2,
		VERDICT_BAD_LENGTH   = 3'd3,
		VERDICT_NO_SYNC      = 3'd4,
		VERDICT_WRONG_DEVICE = 3'd5
	} verdict_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        is_last;
		logic [31:0] image_length;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         verdict;
		logic [COUNT_W-1:0] bytes_seen;
	} out_item_t;

	// Firmware magic "BFNP", one byte per position
	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0:    b = 8'h42;
			2'd1:    b = 8'h46;
			2'd2:    b = 8'h4E;
			2'd3:    b = 8'h50;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bitstream_header_validator.sv =====
// Top level of the bitstream header validator: input register, scan state,
// verdict logic and result register. Depends on bhv_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one header byte per beat and gives one result beat on the byte marked
// is_last. Each byte is held in the input register while the scan logic works
// on it, and the verdict for an image goes from there into the result register
// when the pipe advances; a new byte is taken every cycle while the result
// register is free or being drained. Sync and device patterns are matched on
// the first 4096 bytes of each image; later bytes only end the image. The scan
// state clears itself after each verdict; configuration registers keep their
// values and must be written only while no image is in progress.
module bitstream_header_validator (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire bhv_pkg::in_item_t              in_item,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output bhv_pkg::out_item_t                  out_item,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [bhv_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire [bhv_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam logic [bhv_pkg::COUNT_W-1:0] WINDOW_CNT =
		bhv_pkg::COUNT_W'(bhv_pkg::SCAN_WINDOW);
	localparam logic [bhv_pkg::COUNT_W-1:0] MIN_HDR_CNT =
		bhv_pkg::COUNT_W'(bhv_pkg::MIN_HEADER_BYTES);
	localparam logic [bhv_pkg::COUNT_W-1:0] MAGIC_CNT =
		bhv_pkg::COUNT_W'(bhv_pkg::MAGIC_LEN);

	// Configuration registers
	logic [31:0] min_length_q;
	logic [31:0] max_length_q;
	logic [15:0] sync_pattern_q;
	logic [31:0] device_pattern_q;

	// Input stage
	logic              valid_s1;
	bhv_pkg::in_item_t item_s1;

	// Scan state
	logic [bhv_pkg::COUNT_W-1:0] count_q;
	logic [23:0]                 recent_q;
	logic                        magic_q;
	logic                        sync_q;
	logic                        device_q;

	// Result register
	logic               out_valid_q;
	bhv_pkg::out_item_t out_item_q;

	logic                        advance;
	logic                        process;
	logic                        in_window;
	logic [15:0]                 pair;
	logic [31:0]                 quad;
	logic [bhv_pkg::COUNT_W-1:0] count_nx;
	logic                        magic_nx;
	logic                        sync_nx;
	logic                        device_nx;
	bhv_pkg::verdict_t           verdict_nx;

	// Move the whole pipe when the result register can take a beat
	assign advance   = !out_valid_q || out_ready;
	assign process   = advance && valid_s1;
	assign in_ready  = advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q     <= bhv_pkg::MIN_LENGTH_RST;
			max_length_q     <= bhv_pkg::MAX_LENGTH_RST;
			sync_pattern_q   <= bhv_pkg::SYNC_PATTERN_RST;
			device_pattern_q <= bhv_pkg::DEVICE_PATTERN_RST;
		end else if (cfg_valid) begin
			case (bhv_pkg::cfg_reg_t'(cfg_index))
				bhv_pkg::REG_MIN_LENGTH:     min_length_q     <= cfg_data;
				bhv_pkg::REG_MAX_LENGTH:     max_length_q     <= cfg_data;
				bhv_pkg::REG_SYNC_PATTERN:   sync_pattern_q   <= cfg_data[15:0];
				bhv_pkg::REG_DEVICE_PATTERN: device_pattern_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= in_item;
		end
	end

	// Scan the byte and update the match flags
	always_comb begin
		in_window = count_q < WINDOW_CNT;
		pair      = {recent_q[7:0], item_s1.data_byte};
		quad      = {recent_q, item_s1.data_byte};
		count_nx  = count_q;
		magic_nx  = magic_q;
		sync_nx   = sync_q;
		device_nx = device_q;
		if (in_window) begin
			if (count_q < MAGIC_CNT &&
				item_s1.data_byte != bhv_pkg::magic_byte(count_q[1:0])) begin
				magic_nx = 1'b0;
			end
			if (count_q != '0 && pair == sync_pattern_q) begin
				sync_nx = 1'b1;
			end
			if (count_q >= 3 && quad == device_pattern_q) begin
				device_nx = 1'b1;
			end
			count_nx = count_q + 1'b1;
		end
	end

	// Pick the verdict in check order
	always_comb begin
		if (count_nx < MIN_HDR_CNT) begin
			verdict_nx = bhv_pkg::VERDICT_TOO_SHORT;
		end else if (count_nx >= MAGIC_CNT && magic_nx) begin
			verdict_nx = bhv_pkg::VERDICT_FW_MAGIC;
		end else if (item_s1.image_length < min_length_q ||
			item_s1.image_length > max_length_q) begin
			verdict_nx = bhv_pkg::VERDICT_BAD_LENGTH;
		end else if (!sync_nx) begin
			verdict_nx = bhv_pkg::VERDICT_NO_SYNC;
		end else if (!device_nx) begin
			verdict_nx = bhv_pkg::VERDICT_WRONG_DEVICE;
		end else begin
			verdict_nx = bhv_pkg::VERDICT_ACCEPTED;
		end
	end

	// Hold scan state; clear it after the last byte of an image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			recent_q <= '0;
			magic_q  <= 1'b1;
			sync_q   <= 1'b0;
			device_q <= 1'b0;
		end else if (process) begin
			if (item_s1.is_last) begin
				count_q  <= '0;
				recent_q <= '0;
				magic_q  <= 1'b1;
				sync_q   <= 1'b0;
				device_q <= 1'b0;
			end else begin
				count_q  <= count_nx;
				magic_q  <= magic_nx;
				sync_q   <= sync_nx;
				device_q <= device_nx;
				if (in_window) begin
					recent_q <= quad[23:0];
				end
			end
		end
	end

	// Load the result beat on the last byte, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && item_s1.is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (process && item_s1.is_last) begin
			out_item_q.verdict    <= verdict_nx;
			out_item_q.bytes_seen <= count_nx;
		end
	end

	// Checks
	a_count_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= WINDOW_CNT)
		else $error("byte count beyond scan window");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(process && item_s1.is_last) |=> (count_q == '0 && magic_q && !sync_q && !device_q))
		else $error("scan state not cleared after last byte");

	a_short_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.bytes_seen < MIN_HDR_CNT) |->
		(out_item_q.verdict == bhv_pkg::VERDICT_TOO_SHORT))
		else $error("short image without too-short verdict");

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(process && item_s1.is_last) |=> out_valid_q)
		else $error("last byte gave no result beat");

endmodule

`default_nettype wire

// ===== verif/bitstream_header_validator_tb.sv =====
// Testbench for bitstream_header_validator: a table of directed header images, then random
// images under several register settings, each checked against its table row or a scan model.
// Depends on bhv_pkg and the validator RTL.
`timescale 1ns / 1ps

module bitstream_header_validator_tb;
	import bhv_pkg::*;

	localparam int NOWHERE    = -100;      // pattern offset that places nothing
	localparam int IDLE_GAP   = 6;         // cycles to let the pipeline drain before a write
	localparam int TIMEOUT_NS = 6_000_000;

	// Firmware magic "BFNP"
	localparam logic [7:0] FW_MAGIC_BYTES [MAGIC_LEN] = '{8'h42, 8'h46, 8'h4E, 8'h50};

	typedef enum logic [1:0] {
		LEAD_NONE,
		LEAD_MAGIC,
		LEAD_PARTIAL
	} lead_t;

	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] hi;
		logic [15:0] sync;
		logic [31:0] dev;
	} limits_t;

	// One header image: byte count, lead-in, sync and device offsets, total length,
	// whether the verdict is typed in, that verdict and count, register setting.
	typedef struct packed {
		int          n;
		lead_t       lead;
		int          sync_at;
		int          dev_at;
		logic [31:0] len;
		logic        typed;
		verdict_t    want;
		logic [12:0] seen;
		logic [1:0]  setting;
	} image_case_t;

	localparam limits_t LIMIT_PRESETS [4] = '{
		'{MIN_LENGTH_RST, MAX_LENGTH_RST, SYNC_PATTERN_RST, DEVICE_PATTERN_RST},
		'{32'd0, 32'hFFFF_FFFF, 16'h00C3, 32'h0000_00A7},
		'{32'hFFFF_FFFF, 32'd0, 16'hFFFF, 32'hFFFF_FFFF},
		'{32'd1000, 32'd1000, 16'h0000, 32'h0000_0000}
	};

	localparam int NUM_CASES = 22;
	localparam image_case_t HEADER_CASES [NUM_CASES] = '{
		// too short, magic only in a full-size header, length limits
		'{1, LEAD_NONE, NOWHERE, NOWHERE, 32'd600000, 1'b1, VERDICT_TOO_SHORT, 13'd1, 2'd0},
		'{63, LEAD_NONE, 10, 20, 32'd600000, 1'b1, VERDICT_TOO_SHORT, 13'd63, 2'd0},
		'{4, LEAD_MAGIC, NOWHERE, NOWHERE, 32'd600000, 1'b1, VERDICT_TOO_SHORT, 13'd4, 2'd0},
		'{64, LEAD_MAGIC, 10, 20, 32'd600000, 1'b1, VERDICT_FW_MAGIC, 13'd64, 2'd0},
		'{64, LEAD_PARTIAL, 10, 20, 32'd600000, 1'b0, VERDICT_ACCEPTED, 13'd0, 2'd0},
		'{64, LEAD_NONE, 10, 20, 32'd0, 1'b1, VERDICT_BAD_LENGTH, 13'd64, 2'd0},
		'{64, LEAD_NONE, 10, 20, 32'hFFFF_FFFF, 1'b1, VERDICT_BAD_LENGTH, 13'd64, 2'd0},
		'{64, LEAD_NONE, 10, 20, 32'd524287, 1'b1, VERDICT_BAD_LENGTH, 13'd64, 2'd0},
		'{64, LEAD_NONE, 10, 20, 32'd8388609, 1'b1, VERDICT_BAD_LENGTH, 13'd64, 2'd0},
		// patterns at the very start and at the last byte, limits hit exactly
		'{64, LEAD_NONE, 0, 60, 32'd524288, 1'b0, VERDICT_ACCEPTED, 13'd0, 2'd0},
		'{65, LEAD_NONE, 63, 0, 32'd8388608, 1'b0, VERDICT_ACCEPTED, 13'd0, 2'd0},
		'{64, LEAD_NONE, NOWHERE, 30, 32'd1000000, 1'b0, VERDICT_ACCEPTED, 13'd0, 2'd0},
		'{64, LEAD_NONE, 5, NOWHERE, 32'd1000000, 1'b0, VERDICT_ACCEPTED, 13'd0, 2'd0},
		// reset zeros in the history must not complete a pattern
		'{64, LEAD_NONE, -1, NOWHERE, 32'd12345, 1'b0, VERDICT_ACCEPTED, 13'd0, 2'd1},
		'{64, LEAD_NONE, 20, -3, 32'd0, 1'b0, VERDICT_ACCEPTED, 13'd0, 2'd1},
		'{64, LEAD_NONE, 20, 30, 32'hFFFF_FFFF, 1'b0, VERDICT_ACCEPTED, 13'd0, 2'd1},
		// inverted limits reject every length
		'{64, LEAD_NONE, 10, 20, 32'd0, 1'b1, VERDICT_BAD_LENGTH, 13'd64, 2'd2},
		'{64, LEAD_NONE, 10, 20, 32'hFFFF_FFFF, 1'b1, VERDICT_BAD_LENGTH, 13'd64, 2'd2},
		// single legal length, all-zero patterns
		'{64, LEAD_NONE, NOWHERE, NOWHERE, 32'd1000, 1'b0, VERDICT_ACCEPTED, 13'd0, 2'd3},
		'{64, LEAD_NONE, 40, 50, 32'd1000, 1'b0, VERDICT_ACCEPTED, 13'd0, 2'd3},
		'{64, LEAD_NONE, 40, 50, 32'd999, 1'b1, VERDICT_BAD_LENGTH, 13'd64, 2'd3},
		'{64, LEAD_NONE, 40, 50, 32'd1001, 1'b1, VERDICT_BAD_LENGTH, 13'd64, 2'd3}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_item;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_reg_t   cfg_index;
	logic [31:0] cfg_data;

	// Register mirror and scan state of the local model
	logic [31:0] lim_min;
	logic [31:0] lim_max;
	logic [15:0] sync_word;
	logic [31:0] device_id;
	logic [12:0] scan_count;
	logic [23:0] prev_bytes;
	bit          magic_hold;
	bit          sync_hit;
	bit          device_hit;

	out_item_t pending_verdicts [$];

	bit feed_eager;
	bit drain_eager;
	int err_count;
	int results_checked;
	int bytes_fed;
	int images_fed;
	int settings_applied;
	int tally [8];

	bitstream_header_validator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic void restart_scan();
		scan_count = '0;
		prev_bytes = '0;
		magic_hold = 1'b1;
		sync_hit   = 1'b0;
		device_hit = 1'b0;
	endfunction

	// Advance the scan by one byte; return 1 with the verdict on the last byte
	function automatic bit advance_scan(input in_item_t beat, output out_item_t res);
		logic [7:0] b;
		verdict_t   v;
		b = beat.data_byte;
		res = '0;
		if (scan_count < SCAN_WINDOW) begin
			if (scan_count < MAGIC_LEN && b != FW_MAGIC_BYTES[scan_count[1:0]])
				magic_hold = 1'b0;
			if (scan_count >= 1 && {prev_bytes[7:0], b} == sync_word)
				sync_hit = 1'b1;
			if (scan_count >= 3 && {prev_bytes, b} == device_id)
				device_hit = 1'b1;
			prev_bytes = {prev_bytes[15:0], b};
			scan_count = scan_count + 13'd1;
		end
		if (!beat.is_last)
			return 1'b0;
		if (scan_count < MIN_HEADER_BYTES)
			v = VERDICT_TOO_SHORT;
		else if (scan_count >= MAGIC_LEN && magic_hold)
			v = VERDICT_FW_MAGIC;
		else if (beat.image_length < lim_min || beat.image_length > lim_max)
			v = VERDICT_BAD_LENGTH;
		else if (!sync_hit)
			v = VERDICT_NO_SYNC;
		else if (!device_hit)
			v = VERDICT_WRONG_DEVICE;
		else
			v = VERDICT_ACCEPTED;
		res.verdict    = v;
		res.bytes_seen = scan_count;
		restart_scan();
		return 1'b1;
	endfunction

	function automatic void log_mismatch(string msg);
		err_count++;
		if (err_count <= 10)
			$display("mismatch: %s", msg);
	endfunction

	// Length for a random image: mostly legal, some on and just past the limits
	function automatic logic [31:0] pick_length();
		longint unsigned span;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return $urandom;
		if (sel == 1)
			return lim_min - 32'd1;
		if (sel == 2)
			return lim_max + 32'd1;
		if (sel == 3)
			return $urandom_range(0, 1) ? lim_min : lim_max;
		if (lim_min > lim_max)
			return $urandom;
		span = {32'd0, lim_max} - {32'd0, lim_min} + 64'd1;
		return lim_min + 32'({$urandom, $urandom} % span);
	endfunction

	// Present one beat after a random gap, hold it until taken, then predict
	task automatic push_byte(input in_item_t beat, input bit typed, input out_item_t typed_res);
		int gap;
		out_item_t res;
		gap = feed_eager ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item  <= beat;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (advance_scan(beat, res))
			pending_verdicts.push_back(typed ? typed_res : res);
		bytes_fed++;
		@(negedge clk);
	endtask

	// Build an image from random filler, then lay in magic and patterns
	task automatic send_image(input int n, input lead_t lead, input int sync_at,
		input int dev_at, input logic [31:0] len, input bit typed, input out_item_t typed_res);
		logic [7:0] img [];
		in_item_t beat;
		int k;
		int pos;
		img = new[n];
		for (k = 0; k < n; k++)
			img[k] = $urandom_range(0, 255);
		if (img[0] == FW_MAGIC_BYTES[0])
			img[0] = 8'h43;
		case (lead)
			LEAD_MAGIC: begin
				for (k = 0; k < MAGIC_LEN && k < n; k++)
					img[k] = FW_MAGIC_BYTES[k];
			end
			LEAD_PARTIAL: begin
				pos = $urandom_range(1, 3);
				for (k = 0; k < pos && k < n; k++)
					img[k] = FW_MAGIC_BYTES[k];
				if (pos < n)
					img[pos] = FW_MAGIC_BYTES[pos] ^ 8'($urandom_range(1, 255));
			end
			default: ;
		endcase
		for (k = 0; k < 2; k++) begin
			pos = sync_at + k;
			if (pos >= 0 && pos < n)
				img[pos] = sync_word[15 - 8 * k -: 8];
		end
		for (k = 0; k < 4; k++) begin
			pos = dev_at + k;
			if (pos >= 0 && pos < n)
				img[pos] = device_id[31 - 8 * k -: 8];
		end
		feed_eager = ($urandom_range(0, 3) == 0);
		for (k = 0; k < n; k++) begin
			beat.data_byte    = img[k];
			beat.is_last      = (k == n - 1);
			beat.image_length = beat.is_last ? len : $urandom;
			push_byte(beat, typed, typed_res);
		end
		images_fed++;
	endtask

	// Mostly well-formed images with random content; some short, magic-led or pure noise
	task automatic send_random_image();
		int roll;
		int n;
		int s_at;
		int d_at;
		lead_t lead;
		logic [31:0] len;
		out_item_t no_res;
		roll = $urandom_range(0, 99);
		lead = LEAD_NONE;
		s_at = NOWHERE;
		d_at = NOWHERE;
		no_res = '0;
		if (roll < 15) begin
			n = $urandom_range(1, 70);
			lead = lead_t'($urandom_range(0, 2));
			s_at = int'($urandom_range(0, n)) - 1;
			d_at = int'($urandom_range(0, n + 2)) - 3;
			len = pick_length();
		end else if (roll < 22) begin
			n = $urandom_range(64, 100);
			lead = $urandom_range(0, 1) ? LEAD_MAGIC : LEAD_PARTIAL;
			s_at = int'($urandom_range(0, n)) - 1;
			d_at = int'($urandom_range(0, n + 2)) - 3;
			len = pick_length();
		end else if (roll < 30) begin
			n = $urandom_range(64, 100);
			len = $urandom;
		end else begin
			n = $urandom_range(64, 120);
			if ($urandom_range(0, 9) != 0)
				s_at = int'($urandom_range(0, n)) - 1;
			if ($urandom_range(0, 19) >= 3)
				d_at = int'($urandom_range(0, n + 2)) - 3;
			len = pick_length();
		end
		send_image(n, lead, s_at, d_at, len, 1'b0, no_res);
	endtask

	// Drop the input, wait for every verdict, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (IDLE_GAP) @(negedge clk);
	endtask

	// Write all four registers back to back; junk in the unused sync bits
	task automatic apply_setting(input limits_t s);
		logic [31:0] word [4];
		logic [15:0] junk;
		junk = $urandom_range(0, 65535);
		word[0] = s.lo;
		word[1] = s.hi;
		word[2] = {junk, s.sync};
		word[3] = s.dev;
		cfg_valid <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= word[i];
			do @(posedge clk); while (!cfg_ready);
			case (cfg_reg_t'(i))
				REG_MIN_LENGTH:     lim_min = word[i];
				REG_MAX_LENGTH:     lim_max = word[i];
				REG_SYNC_PATTERN:   sync_word = word[i][15:0];
				REG_DEVICE_PATTERN: device_id = word[i];
				default: ;
			endcase
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	// Stimulus: reset, directed table, random phases, then the verdict
	initial begin : stimulus
		image_case_t row;
		out_item_t typed_res;
		limits_t preset;
		int cur_setting;
		int first_byte;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MIN_LENGTH;
		cfg_data  = '0;
		lim_min   = MIN_LENGTH_RST;
		lim_max   = MAX_LENGTH_RST;
		sync_word = SYNC_PATTERN_RST;
		device_id = DEVICE_PATTERN_RST;
		restart_scan();
		cur_setting = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < NUM_CASES; r++) begin
			row = HEADER_CASES[r];
			if (row.setting != cur_setting) begin
				settle();
				apply_setting(LIMIT_PRESETS[row.setting]);
				cur_setting = row.setting;
			end
			typed_res.verdict    = row.want;
			typed_res.bytes_seen = row.seen;
			send_image(row.n, row.lead, row.sync_at, row.dev_at, row.len, row.typed,
				typed_res);
		end

		for (int ph = 0; ph < 3; ph++) begin
			settle();
			if (ph == 0) begin
				preset = LIMIT_PRESETS[0];
			end else begin
				preset.lo   = $urandom_range(0, 2_000_000);
				preset.hi   = preset.lo + $urandom_range(1, 50_000_000);
				preset.sync = $urandom_range(0, 65535);
				preset.dev  = $urandom;
			end
			apply_setting(preset);
			first_byte = bytes_fed;
			while (bytes_fed - first_byte < 60)
				send_random_image();
		end

		settle();
		$display("covered %0d header bytes in %0d images under %0d register settings",
			bytes_fed, images_fed, settings_applied);
		$display("verdicts: accepted %0d, short %0d, magic %0d, length %0d, sync %0d, dev %0d",
			tally[0], tally[1], tally[2], tally[3], tally[4], tally[5]);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Result side: stall at random, compare each beat with the oldest verdict
	initial begin : drain
		int stall;
		out_item_t got;
		out_item_t want;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0)
				drain_eager = ~drain_eager;
			stall = drain_eager ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = out_item;
			if (pending_verdicts.size() == 0) begin
				log_mismatch($sformatf("beat with no image pending: verdict %0d, bytes_seen %0d",
					got.verdict, got.bytes_seen));
			end else begin
				want = pending_verdicts.pop_front();
				if (got.verdict !== want.verdict)
					log_mismatch($sformatf("result %0d verdict: expected %0d, got %0d",
						results_checked, want.verdict, got.verdict));
				if (got.bytes_seen !== want.bytes_seen)
					log_mismatch($sformatf("result %0d bytes_seen: expected %0d, got %0d",
						results_checked, want.bytes_seen, got.bytes_seen));
			end
			if (!$isunknown(got.verdict))
				tally[got.verdict]++;
			results_checked++;
			@(negedge clk);
		end
	end

	// Hard stop if the handshakes hang
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("run stalled with %0d verdicts outstanding", pending_verdicts.size());
		$display("status: fail");
		$finish;
	end

endmodule
